// ----- rtl/pira_pkg.sv -----
// ----------------------------------------------------------------------------
// pira_pkg
// Types and codes shared by the positional insert/remove list and its checker.
// ----------------------------------------------------------------------------
package pira_pkg;

  // Operation kinds carried by a request
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Commands broadcast to the cell row
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] position;
  } cell_cmd_t;

endpackage

// ----- rtl/pira_cell.sv -----
// ----------------------------------------------------------------------------
// pira_cell
// One list slot: holds an element and moves it to or from its neighbors
// under the broadcast command.
// ----------------------------------------------------------------------------
module pira_cell #(
  parameter int EW    = 32,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  pira_pkg::cell_cmd_t cmd,
  input  logic [EW-1:0]       din,
  input  logic [EW-1:0]       lower,
  input  logic [EW-1:0]       upper,
  output logic [EW-1:0]       data,
  output logic [EW-1:0]       tap
);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (32'(cmd.position) == 32'(INDEX));
  assign above_pos = (32'(INDEX) > 32'(cmd.position));

  always_ff @(posedge clk) begin
    case (cmd.op)
      pira_pkg::CMD_INSERT: begin
        if (at_pos) begin
          data <= din;
        end else if (above_pos) begin
          data <= lower;
        end
      end
      pira_pkg::CMD_REMOVE: begin
        // close the gap: this slot and everything above take the next one up
        if (at_pos || above_pos) begin
          data <= upper;
        end
      end
      default: begin
      end
    endcase
  end

  // read tap: zero unless this slot is the one being read
  always_ff @(posedge clk) begin
    if (cmd.op == pira_pkg::CMD_READ && at_pos) begin
      tap <= data;
    end else begin
      tap <= '0;
    end
  end

endmodule

// ----- rtl/positional_insert_remove_array.sv -----
// ----------------------------------------------------------------------------
// positional_insert_remove_array
// Fixed-capacity contiguous list in a row of shifting cells. Insert, remove,
// read or clear by position; every request returns one response.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------
//  req      | in        | req_valid/req_ready  | kind, position, value
//  rsp      | out       | rsp_valid/rsp_ready  | read_value, count, status
//
//  For a request, the cells shift and latch their read taps on the transfer
//  edge, and the taps are combined into the response register on the next.
//  One request is in flight at a time; req_ready returns once the response
//  has been taken, so a stalled rsp holds off req.
//  Reset clears the entry count and holds req_ready low; cells keep their data.
// ----------------------------------------------------------------------------
module positional_insert_remove_array #(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pira_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pira_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > pira_pkg::POS_W) ? CNT_W : pira_pkg::POS_W;
  localparam int EW    = ELEMENT_WIDTH;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             busy;
  logic             accept;

  logic [1:0]          status_next;
  pira_pkg::cell_cmd_t cmd;
  logic [CMP_W-1:0]    pos_w;
  logic [CMP_W-1:0]    cnt_w;
  logic [CMP_W-1:0]    cnt_after_w;
  logic [63:0]         value_wide;
  logic [EW-1:0]       din;

  logic [EW-1:0] cell_data [CAPACITY];
  logic [EW-1:0] cell_tap  [CAPACITY];
  logic [EW-1:0] tap_or;
  logic [63:0]   tap_wide;

  assign accept    = req_valid && req_ready;
  assign req_ready = !rst && !busy && !rsp_valid;

  assign pos_w      = CMP_W'(req.position);
  assign cnt_w      = CMP_W'(count);
  assign value_wide = 64'(req.value);
  assign din        = value_wide[EW-1:0];

  always_comb begin
    status_next  = pira_pkg::ST_OK;
    count_next   = count;
    cmd.op       = pira_pkg::CMD_HOLD;
    cmd.position = req.position;
    case (req.kind)
      pira_pkg::KIND_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          status_next = pira_pkg::ST_FULL;
        end else if (pos_w > cnt_w) begin
          status_next = pira_pkg::ST_RANGE;
        end else begin
          cmd.op     = pira_pkg::CMD_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      pira_pkg::KIND_REMOVE, pira_pkg::KIND_READ: begin
        if (count == '0) begin
          status_next = pira_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_next = pira_pkg::ST_RANGE;
        end else if (req.kind == pira_pkg::KIND_REMOVE) begin
          cmd.op     = pira_pkg::CMD_REMOVE;
          count_next = count - CNT_W'(1);
        end else begin
          cmd.op = pira_pkg::CMD_READ;
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
    // cells only act on a transfer
    if (!accept) begin
      cmd.op = pira_pkg::CMD_HOLD;
    end
  end

  assign cnt_after_w = CMP_W'(count_next);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EW-1:0] lower;
    logic [EW-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = din;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    pira_cell #(
      .EW    (EW),
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .din   (din),
      .lower (lower),
      .upper (upper),
      .data  (cell_data[i]),
      .tap   (cell_tap[i])
    );
  end

  // at most one tap is nonzero
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  assign tap_wide = 64'(tap_or);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        busy  <= 1'b1;
      end
      if (busy) begin
        busy      <= 1'b0;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.count  <= cnt_after_w[pira_pkg::COUNT_W-1:0];
      rsp.status <= status_next;
    end
    if (busy) begin
      rsp.read_value <= tap_wide[pira_pkg::VALUE_W-1:0];
    end
  end

endmodule

// ----- rtl/pira_checker.sv -----
// ----------------------------------------------------------------------------
// pira_checker
// Port-level checks for the positional insert/remove list.
// ----------------------------------------------------------------------------
module pira_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input pira_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input pira_pkg::rsp_t rsp
);

  // a stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  // each request transfer yields a response
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##2 rsp_valid)
    else $error("response missing after request");

  // clear always succeeds and empties the list
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.kind == pira_pkg::KIND_CLEAR
    |-> ##2 (rsp.count == '0 && rsp.status == pira_pkg::ST_OK))
    else $error("clear did not empty the list");

  // failed operations return no data
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != pira_pkg::ST_OK |-> rsp.read_value == '0)
    else $error("read value on failed operation");

endmodule

bind positional_insert_remove_array pira_checker u_pira_checker (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional insert/remove list. A short table of
// directed operations walks the list from empty to full and back; 1425
// random operations then follow under three idle patterns on the request
// and response channels. Every response is checked in order, against the
// table's expected result or an in-bench model of the list.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP       = 16;
  localparam int IDX_W          = $clog2(LIST_CAP);
  localparam int ITEMS_PER_PASS = 475;
  localparam int STALL_CYCLES   = 400;
  localparam int MAX_SHOWN      = 10;

  typedef struct {
    pira_pkg::req_t op;
    bit             typed;
    pira_pkg::rsp_t want;
  } list_case_t;

  logic           clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           rsp_ready = 1'b0;
  pira_pkg::req_t req       = '0;
  logic           req_ready;
  logic           rsp_valid;
  pira_pkg::rsp_t rsp;

  // list model
  logic [pira_pkg::VALUE_W-1:0] list_entries [LIST_CAP];
  logic [pira_pkg::COUNT_W-1:0] list_len = '0;
  bit                           growing  = 1'b1;

  pira_pkg::rsp_t expected_rsp_q [$];
  list_case_t     walk_cases [$];
  int             rsp_mismatches = 0;
  int             snd_idle_pct   = 37;
  int             rcv_idle_pct   = 83;
  logic           rsp_holdoff    = 1'b0;
  int             kind_sent [4]  = '{0, 0, 0, 0};
  int             status_seen [4] = '{0, 0, 0, 0};
  event           rsp_stall_ev;

  positional_insert_remove_array #(
    .CAPACITY      (LIST_CAP),
    .ELEMENT_WIDTH (pira_pkg::VALUE_W)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic pira_pkg::rsp_t predict_list_op(input pira_pkg::req_t op);
    pira_pkg::rsp_t res;
    int             k;
    int             src;
    res = '0;
    res.status = pira_pkg::ST_OK;
    case (op.kind)
      pira_pkg::KIND_INSERT: begin
        if (list_len >= LIST_CAP) begin
          res.status = pira_pkg::ST_FULL;
        end else if (op.position > list_len) begin
          res.status = pira_pkg::ST_RANGE;
        end else begin
          for (k = int'(list_len); k > int'(op.position); k--) begin
            src = k - 1;
            list_entries[k[IDX_W-1:0]] = list_entries[src[IDX_W-1:0]];
          end
          list_entries[op.position[IDX_W-1:0]] = op.value;
          list_len = list_len + 1'b1;
        end
      end
      pira_pkg::KIND_REMOVE: begin
        if (list_len == 0) begin
          res.status = pira_pkg::ST_EMPTY;
        end else if (op.position >= list_len) begin
          res.status = pira_pkg::ST_RANGE;
        end else begin
          for (k = int'(op.position); k + 1 < int'(list_len); k++) begin
            src = k + 1;
            list_entries[k[IDX_W-1:0]] = list_entries[src[IDX_W-1:0]];
          end
          list_len = list_len - 1'b1;
        end
      end
      pira_pkg::KIND_READ: begin
        if (list_len == 0) begin
          res.status = pira_pkg::ST_EMPTY;
        end else if (op.position >= list_len) begin
          res.status = pira_pkg::ST_RANGE;
        end else begin
          res.read_value = list_entries[op.position[IDX_W-1:0]];
        end
      end
      default: begin
        list_len = '0;
      end
    endcase
    res.count = list_len;
    return res;
  endfunction

  function automatic pira_pkg::req_t pick_list_op();
    pira_pkg::req_t op;
    int             roll;
    int             ins_pct;
    int             rem_pct;
    if (list_len == LIST_CAP) growing = 1'b0;
    else if (list_len == 0) growing = 1'b1;
    else if ($urandom_range(39) == 0) growing = !growing;
    ins_pct = growing ? 55 : 18;
    rem_pct = growing ? 15 : 50;
    roll = $urandom_range(99);
    op.value = $urandom();
    if (roll < 3) op.kind = pira_pkg::KIND_CLEAR;
    else if (roll < 3 + ins_pct) op.kind = pira_pkg::KIND_INSERT;
    else if (roll < 3 + ins_pct + rem_pct) op.kind = pira_pkg::KIND_REMOVE;
    else op.kind = pira_pkg::KIND_READ;
    // mostly legal positions, some anywhere in the field
    if ($urandom_range(9) == 0)
      op.position = pira_pkg::POS_W'($urandom_range(31));
    else if (op.kind == pira_pkg::KIND_INSERT)
      op.position = pira_pkg::POS_W'($urandom_range(list_len));
    else if (list_len == 0)
      op.position = '0;
    else
      op.position = pira_pkg::POS_W'($urandom_range(list_len - 1));
    return op;
  endfunction

  task automatic add_case(input logic [1:0] kind, input int pos, input logic [31:0] val,
                          input bit typed, input logic [31:0] want_val,
                          input int want_count, input logic [1:0] want_status);
    list_case_t c;
    c.op.kind          = kind;
    c.op.position      = pos[pira_pkg::POS_W-1:0];
    c.op.value         = val;
    c.typed            = typed;
    c.want.read_value  = want_val;
    c.want.count       = want_count[pira_pkg::COUNT_W-1:0];
    c.want.status      = want_status;
    walk_cases.push_back(c);
  endtask

  // Hold valid until the transfer, then record the expected response.
  task automatic offer_op(input pira_pkg::req_t op, input bit typed,
                          input pira_pkg::rsp_t want);
    pira_pkg::rsp_t predicted;
    req       <= op;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = predict_list_op(op);
    expected_rsp_q.push_back(typed ? want : predicted);
    kind_sent[op.kind]++;
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
  endtask

  task automatic drain_list();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_rsp_q.size() != 0);
  endtask

  // response side: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !rsp_holdoff && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(rsp_stall_ev);
      rsp_holdoff <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clk);
      rsp_holdoff <= 1'b0;
    end
  end

  always @(posedge clk) begin : rsp_check
    pira_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        if (rsp_mismatches < MAX_SHOWN)
          $display("[%0t] unexpected response: value=%h count=%0d status=%0d",
                   $realtime, rsp.read_value, rsp.count, rsp.status);
        rsp_mismatches++;
      end else begin
        want = expected_rsp_q.pop_front();
        status_seen[rsp.status]++;
        if (rsp.read_value !== want.read_value || rsp.count !== want.count ||
            rsp.status !== want.status) begin
          if (rsp_mismatches < MAX_SHOWN)
            $display({"[%0t] mismatch: value %h/%h count %0d/%0d status %0d/%0d",
                      " (exp/act)"},
                     $realtime, want.read_value, rsp.read_value, want.count, rsp.count,
                     want.status, rsp.status);
          rsp_mismatches++;
        end
      end
    end
  end

  initial begin
    pira_pkg::rsp_t none;
    none = '0;

    // empty list, then grow, fill, overflow and shrink
    add_case(pira_pkg::KIND_READ,    0, 32'h1234_5678, 1, '0, 0, pira_pkg::ST_EMPTY);
    add_case(pira_pkg::KIND_REMOVE,  0, '0,            1, '0, 0, pira_pkg::ST_EMPTY);
    add_case(pira_pkg::KIND_INSERT,  1, 32'h0000_0001, 1, '0, 0, pira_pkg::ST_RANGE);
    add_case(pira_pkg::KIND_INSERT,  0, 32'hFFFF_FFFF, 1, '0, 1, pira_pkg::ST_OK);
    add_case(pira_pkg::KIND_READ,    0, '0,            1, 32'hFFFF_FFFF, 1, pira_pkg::ST_OK);
    add_case(pira_pkg::KIND_READ,   31, '0,            1, '0, 1, pira_pkg::ST_RANGE);
    add_case(pira_pkg::KIND_REMOVE,  1, '0,            1, '0, 1, pira_pkg::ST_RANGE);
    add_case(pira_pkg::KIND_INSERT,  0, 32'h0000_0000, 1, '0, 2, pira_pkg::ST_OK);
    add_case(pira_pkg::KIND_INSERT,  2, 32'hA5A5_A5A5, 1, '0, 3, pira_pkg::ST_OK);
    add_case(pira_pkg::KIND_INSERT,  1, 32'h5A5A_5A5A, 0, '0, 0, pira_pkg::ST_OK);
    for (int i = 0; i < 12; i++)
      add_case(pira_pkg::KIND_INSERT, (i % 3 == 0) ? 0 : (i % 3 == 1) ? 2 + i / 2 : 4 + i,
               32'hC0DE_0000 + i, 0, '0, 0, pira_pkg::ST_OK);
    add_case(pira_pkg::KIND_INSERT, 31, 32'hDEAD_BEEF, 1, '0, 16, pira_pkg::ST_FULL);
    add_case(pira_pkg::KIND_READ,   16, '0,            1, '0, 16, pira_pkg::ST_RANGE);
    add_case(pira_pkg::KIND_READ,   15, '0,            0, '0, 0, pira_pkg::ST_OK);
    add_case(pira_pkg::KIND_REMOVE, 15, '0,            0, '0, 0, pira_pkg::ST_OK);
    add_case(pira_pkg::KIND_REMOVE,  0, '0,            0, '0, 0, pira_pkg::ST_OK);
    add_case(pira_pkg::KIND_CLEAR,   0, '0,            1, '0, 0, pira_pkg::ST_OK);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (walk_cases[i]) begin
      if (i > 0) sender_gap();
      offer_op(walk_cases[i].op, walk_cases[i].typed, walk_cases[i].want);
    end
    drain_list();

    for (int pass = 0; pass < 3; pass++) begin
      snd_idle_pct = (pass == 0) ? 37 : (pass == 1) ? 83 : 0;
      rcv_idle_pct = (pass == 0) ? 83 : (pass == 1) ? 37 : 0;
      for (int i = 0; i < ITEMS_PER_PASS; i++) begin
        if (i > 0) sender_gap();
        if (pass == 2 && i == 150) -> rsp_stall_ev;
        offer_op(pick_list_op(), 1'b0, none);
      end
      drain_list();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d inserts, %0d removes, %0d reads, %0d clears under three idle mixes",
             kind_sent[pira_pkg::KIND_INSERT], kind_sent[pira_pkg::KIND_REMOVE],
             kind_sent[pira_pkg::KIND_READ], kind_sent[pira_pkg::KIND_CLEAR]);
    $display("Responses: %0d ok, %0d full, %0d out of range, %0d empty; %0d mismatches",
             status_seen[pira_pkg::ST_OK], status_seen[pira_pkg::ST_FULL],
             status_seen[pira_pkg::ST_RANGE], status_seen[pira_pkg::ST_EMPTY],
             rsp_mismatches);
    if (rsp_mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
